@@ sv/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// Used by spq_cell, stable_priority_queue_core, spq_checker, spq_scoreboard and the bench.
package spq_pkg;

  localparam int KEY_W   = 4;
  localparam int ID_W    = 16;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_INSERT_FULL = 2'd2
  } status_t;

  // broadcast to every cell for one request
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } spq_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic             keep;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } spq_link_t;

endpackage

@@ sv/spq_cell.sv @@
// One slot of the sorted chain: holds one entry, shifts down on insert
// and up on pop. Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  logic              occ,     // slot holds a live entry
  input  spq_pkg::spq_link_t up,     // neighbor toward the head
  input  spq_pkg::spq_link_t down,   // neighbor toward the tail
  output spq_pkg::spq_link_t link,
  output logic [spq_pkg::KEY_W-1:0] nxt_key,
  output logic [spq_pkg::ID_W-1:0]  nxt_id
);

  logic [spq_pkg::KEY_W-1:0] key;
  logic [spq_pkg::ID_W-1:0]  id;
  logic                      keep;

  // keep is a prefix of the chain since entries are sorted descending
  assign keep = occ && (key >= ctrl.key);

  always_comb begin
    nxt_key = key;
    nxt_id  = id;
    if (ctrl.ins) begin
      if (!keep) begin
        if (up.keep) begin
          nxt_key = ctrl.key;
          nxt_id  = ctrl.id;
        end else begin
          nxt_key = up.key;
          nxt_id  = up.id;
        end
      end
    end else if (ctrl.pop) begin
      nxt_key = down.key;
      nxt_id  = down.id;
    end
  end

  always_ff @(posedge clk) begin
    key <= nxt_key;
    id  <= nxt_id;
  end

  assign link = '{keep: keep, key: key, id: id};

endmodule

@@ sv/stable_priority_queue_core.sv @@
// Stable priority queue: usage
//   Slave channel s_*: one request per transfer. s_tuser is the operation
//   (0 insert, 1 pop); s_tdata carries the key and identifier of an insert.
//   Master channel m_*: exactly one result per request, in request order,
//   with status, popped entry, head after the request and entry count.
//   Higher keys are served first; equal keys leave in arrival order.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while each result is taken; every
//   slot of the cell chain compares the new key and shifts in the same
//   cycle, so the rate is set by the single result register.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken, or rises again in the cycle it is.
//   Reset (rst, synchronous) empties the queue and drops any pending
//   result; slot contents are left as they are and never read while empty.
//   A pop on an empty queue and an insert into a full queue change nothing
//   and are flagged in the status field.
// Depends on spq_pkg and spq_cell.
module stable_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] priority_key, [19:4] entry_id, [23:20] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [1:0] status, [5:2] popped_key, [21:6] popped_id,
                                 // [22] head_valid, [26:23] head_key, [42:27] head_id,
                                 // [47:43] entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          accept;
  logic          full;
  logic          empty;
  spq_pkg::op_t  op;
  spq_pkg::status_t status;
  spq_pkg::spq_ctrl_t ctrl;

  spq_pkg::spq_link_t            link    [DEPTH];
  logic [spq_pkg::KEY_W-1:0]     nxt_key [DEPTH];
  logic [spq_pkg::ID_W-1:0]      nxt_id  [DEPTH];

  logic [spq_pkg::KEY_W-1:0] popped_key;
  logic [spq_pkg::ID_W-1:0]  popped_id;
  logic                      head_valid;
  logic [spq_pkg::KEY_W-1:0] head_key;
  logic [spq_pkg::ID_W-1:0]  head_id;
  logic [CW+4:0]             cnt_wide;
  logic [47:0]               result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = spq_pkg::op_t'(s_tuser);
  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);

  always_comb begin
    ctrl.ins = accept && (op == spq_pkg::OP_INSERT) && !full;
    ctrl.pop = accept && (op == spq_pkg::OP_POP) && !empty;
    ctrl.key = s_tdata[3:0];
    ctrl.id  = s_tdata[19:4];
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + CW'(1);
    end else if (ctrl.pop) begin
      cnt_next = cnt - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::spq_link_t up;
    spq_pkg::spq_link_t down;
    logic               occ;

    assign occ = (CW'(i) < cnt);
    if (i == 0) begin : g_head
      assign up = '{keep: 1'b1, key: '0, id: '0};
    end else begin : g_mid
      assign up = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign down = '0;
    end else begin : g_body
      assign down = link[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .occ     (occ),
      .up      (up),
      .down    (down),
      .link    (link[i]),
      .nxt_key (nxt_key[i]),
      .nxt_id  (nxt_id[i])
    );
  end

  always_comb begin
    status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_INSERT && full) begin
      status = spq_pkg::ST_INSERT_FULL;
    end else if (op == spq_pkg::OP_POP && empty) begin
      status = spq_pkg::ST_POP_EMPTY;
    end
  end

  always_comb begin
    popped_key = '0;
    popped_id  = '0;
    if (ctrl.pop) begin
      popped_key = link[0].key;
      popped_id  = link[0].id;
    end
    head_valid = (cnt_next != '0);
    head_key   = head_valid ? nxt_key[0] : '0;
    head_id    = head_valid ? nxt_id[0] : '0;
    cnt_wide   = {5'd0, cnt_next};
    result     = {cnt_wide[4:0], head_id, head_key, head_valid,
                  popped_id, popped_key, status};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result;
    end
  end

endmodule

@@ sv/spq_checker.sv @@
// Port-level checks for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_core.
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  localparam logic [4:0] FULL5 = 5'(DEPTH);

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // pop on empty leaves the queue empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == spq_pkg::ST_POP_EMPTY) |->
      (m_tdata[47:43] == 5'd0) && !m_tdata[22])
    else $error("empty-pop result shows entries");

  // dropped insert only when full, and nothing popped
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == spq_pkg::ST_INSERT_FULL) |->
      (m_tdata[47:43] == FULL5) && (m_tdata[21:2] == 20'd0))
    else $error("dropped insert with queue not full");

  // head is reported zero when empty
  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[22] |-> (m_tdata[42:23] == 20'd0))
    else $error("head fields set on empty queue");

endmodule

bind stable_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/spq_checker.sv @@
// Scoreboard for stable_priority_queue_core: watches both stream channels,
// predicts each result from its own sorted queue model and compares it.
// Depends on spq_pkg.
`timescale 1ns / 100ps

module spq_scoreboard #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int          mismatches,
  output int          pending
);

  // same layout as m_tdata, highest field first
  typedef struct packed {
    logic [spq_pkg::COUNT_W-1:0] entry_count;
    logic [spq_pkg::ID_W-1:0]    head_id;
    logic [spq_pkg::KEY_W-1:0]   head_key;
    logic                        head_valid;
    logic [spq_pkg::ID_W-1:0]    popped_id;
    logic [spq_pkg::KEY_W-1:0]   popped_key;
    spq_pkg::status_t            status;
  } queue_result_t;

  logic [spq_pkg::KEY_W-1:0] slot_key [DEPTH];
  logic [spq_pkg::ID_W-1:0]  slot_id  [DEPTH];
  int                        fill;
  queue_result_t             expected_results[$];

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
      mismatches++;
    end
  endtask

  function automatic queue_result_t serve_request(input spq_pkg::op_t op,
                                                  input logic [spq_pkg::KEY_W-1:0] key,
                                                  input logic [spq_pkg::ID_W-1:0] id);
    queue_result_t r;
    int pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (fill >= DEPTH) begin
        r.status = spq_pkg::ST_INSERT_FULL;
      end else begin
        // new entry goes behind every entry with an equal or higher key
        pos = 0;
        while (pos < fill && slot_key[pos] >= key) pos++;
        for (int i = fill; i > pos; i--) begin
          slot_key[i] = slot_key[i-1];
          slot_id[i]  = slot_id[i-1];
        end
        slot_key[pos] = key;
        slot_id[pos]  = id;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = spq_pkg::ST_POP_EMPTY;
      end else begin
        r.popped_key = slot_key[0];
        r.popped_id  = slot_id[0];
        for (int i = 1; i < fill; i++) begin
          slot_key[i-1] = slot_key[i];
          slot_id[i-1]  = slot_id[i];
        end
        fill--;
      end
    end
    if (fill > 0) begin
      r.head_valid = 1'b1;
      r.head_key   = slot_key[0];
      r.head_id    = slot_id[0];
    end
    r.entry_count = fill[spq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      fill = 0;
      expected_results.delete();
    end else begin
      // the result leaving now belongs to an earlier request
      if (m_tvalid && m_tready) begin
        got = queue_result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: %h", $realtime, m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report("status", 16'(got.status), 16'(want.status));
          report("popped_key", 16'(got.popped_key), 16'(want.popped_key));
          report("popped_id", got.popped_id, want.popped_id);
          report("head_valid", 16'(got.head_valid), 16'(want.head_valid));
          report("head_key", 16'(got.head_key), 16'(want.head_key));
          report("head_id", got.head_id, want.head_id);
          report("entry_count", 16'(got.entry_count), 16'(want.entry_count));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(serve_request(spq_pkg::op_t'(s_tuser),
                                                 s_tdata[spq_pkg::KEY_W-1:0],
                                                 s_tdata[spq_pkg::KEY_W +: spq_pkg::ID_W]));
    end
    pending <= expected_results.size();
  end

endmodule

@@ sim/tb_stable_priority_queue_core.sv @@
// Top of the stable_priority_queue_core bench: clock, reset, request and result-side
// traffic, watchdog and verdict. Depends on spq_pkg, spq_scoreboard and the DUT.
`timescale 1ns / 100ps

module tb_stable_priority_queue_core;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 150;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic        s_tuser  = spq_pkg::OP_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_req     = 1'b0;
  int quiet_cycles   = 0;

  always #5 clk = ~clk;

  stable_priority_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  spq_scoreboard #(.DEPTH(DEPTH)) u_scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .pending(pending)
  );

  // result side: random stalls, or a long hold-off when hold_req toggles
  initial begin
    logic hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("stable_priority_queue_core verification failed");
        $finish;
      end
    end
  end

  task automatic offer_request(input spq_pkg::op_t op,
                               input logic [spq_pkg::KEY_W-1:0] key,
                               input logic [spq_pkg::ID_W-1:0] id);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, id, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic random_request(input int insert_pct);
    spq_pkg::op_t              op;
    logic [spq_pkg::KEY_W-1:0] key;
    op  = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
    // narrow key range half the time so ties are common
    key = $urandom_range(1) ? spq_pkg::KEY_W'($urandom_range(3))
                            : spq_pkg::KEY_W'($urandom_range(15));
    sender_gap();
    offer_request(op, key, spq_pkg::ID_W'($urandom()));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_tbl[4];
    int stall_tbl[4];
    idle_tbl  = '{0, 48, 0, 11};
    stall_tbl = '{0, 0, 48, 11};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, key and id extremes, ties kept in arrival order
    offer_request(spq_pkg::OP_POP, 4'hF, 16'hFFFF);
    offer_request(spq_pkg::OP_INSERT, 4'h0, 16'h0000);
    offer_request(spq_pkg::OP_INSERT, 4'hF, 16'hFFFF);
    offer_request(spq_pkg::OP_INSERT, 4'hF, 16'h1234);
    offer_request(spq_pkg::OP_INSERT, 4'h0, 16'h0005);
    offer_request(spq_pkg::OP_INSERT, 4'h7, 16'hA5A5);
    offer_request(spq_pkg::OP_INSERT, 4'h8, 16'h5A5A);
    repeat (7) offer_request(spq_pkg::OP_POP, 4'h0, 16'h0000);
    // fill to the top, then one dropped insert
    for (int i = 0; i < DEPTH; i++)
      offer_request(spq_pkg::OP_INSERT, spq_pkg::KEY_W'(i % 3), spq_pkg::ID_W'(i));
    offer_request(spq_pkg::OP_INSERT, 4'hF, 16'hBEEF);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  <= idle_tbl[ph];
      recv_stall_pct <= stall_tbl[ph];
      @(posedge clk);
      if (ph == 0) begin
        // hold the result side off while requests keep coming
        hold_req <= ~hold_req;
        repeat (25) random_request(70);
      end
      for (int seg = 0; seg < 5; seg++)
        repeat (44) random_request(seg[0] ? 25 : 78);
      drain_results();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("stable_priority_queue_core verification clean");
    end else begin
      $display("stable_priority_queue_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue_core.sv
sv/spq_checker.sv
sim/spq_checker.sv
sim/tb_stable_priority_queue_core.sv
